// ===== src/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// uvs_pkg: shared types, constants and functions of the UV sphere tessellator
// Divider geometry, sine coefficients, register map, per-vertex schedule.
// ----------------------------------------------------------------------------
package uvs_pkg;

	localparam int MAX_DIVISIONS_DEF = 1024;

	// Divider chain geometry: numerator, quotient and divisor widths
	localparam int DIV_NW = 27;
	localparam int DIV_QW = 17;
	localparam int DIV_DW = 12;

	localparam int SINE_LAT = 4;

	localparam logic [15:0] SIN_A = 16'd25736;
	localparam logic [15:0] SIN_B = 16'd10512;
	localparam logic [15:0] SIN_C = 16'd1160;

	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_SLICES = 2'd1;
	localparam logic [1:0] REG_STACKS = 2'd2;

	typedef enum logic [1:0] {
		KIND_TOP,
		KIND_BOT,
		KIND_MID
	} cell_kind_t;

	typedef struct packed {
		logic da;
		logic db;
		logic pole;
		logic last;
	} vtx_info_t;

	// Grid offset, pole flag and last flag of vertex idx of a cell
	function automatic vtx_info_t vtx_info(cell_kind_t kind, logic [2:0] idx);
		vtx_info_t v;
		v = '0;
		unique case (kind)
			KIND_TOP: begin
				case (idx)
					3'd0: v = '{da: 1'b0, db: 1'b0, pole: 1'b1, last: 1'b0};
					3'd1: v = '{da: 1'b1, db: 1'b1, pole: 1'b0, last: 1'b0};
					default: v = '{da: 1'b1, db: 1'b0, pole: 1'b0, last: 1'b1};
				endcase
			end
			KIND_BOT: begin
				case (idx)
					3'd0: v = '{da: 1'b0, db: 1'b0, pole: 1'b0, last: 1'b0};
					3'd1: v = '{da: 1'b0, db: 1'b1, pole: 1'b0, last: 1'b0};
					default: v = '{da: 1'b1, db: 1'b0, pole: 1'b1, last: 1'b1};
				endcase
			end
			KIND_MID: begin
				case (idx)
					3'd0: v = '{da: 1'b0, db: 1'b0, pole: 1'b0, last: 1'b0};
					3'd1: v = '{da: 1'b0, db: 1'b1, pole: 1'b0, last: 1'b0};
					3'd2: v = '{da: 1'b1, db: 1'b0, pole: 1'b0, last: 1'b0};
					3'd3: v = '{da: 1'b0, db: 1'b1, pole: 1'b0, last: 1'b0};
					3'd4: v = '{da: 1'b1, db: 1'b1, pole: 1'b0, last: 1'b0};
					default: v = '{da: 1'b1, db: 1'b0, pole: 1'b0, last: 1'b1};
				endcase
			end
			default: v = '{da: 1'b1, db: 1'b0, pole: 1'b0, last: 1'b1};
		endcase
		return v;
	endfunction

	// Drop 14 fraction bits, rounding half away from zero
	function automatic logic signed [17:0] rmul14(logic signed [32:0] p);
		logic        neg;
		logic [32:0] m;
		logic [32:0] r;
		neg = p[32];
		m = neg ? 33'(-p) : 33'(p);
		r = (m + 33'd8192) >> 14;
		return neg ? -$signed(r[17:0]) : $signed(r[17:0]);
	endfunction

endpackage

// ===== src/uvs_div_cell.sv =====
// ----------------------------------------------------------------------------
// uvs_div_cell: one restoring division step
// Shift in one numerator bit, subtract the divisor where it fits, register.
// ----------------------------------------------------------------------------
module uvs_div_cell #(
	parameter int QW = uvs_pkg::DIV_QW,
	parameter int DW = uvs_pkg::DIV_DW
) (
	input  logic          clk,
	input  logic [DW-1:0] divisor,
	input  logic [DW-1:0] rem_in,
	input  logic [QW-1:0] num_in,
	input  logic [QW-1:0] quo_in,
	output logic [DW-1:0] rem_out,
	output logic [QW-1:0] num_out,
	output logic [QW-1:0] quo_out
);
	logic [DW:0]   trial;
	logic          fit;
	logic [DW:0]   diff;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] num_q;
	logic [QW-1:0] quo_q;

	assign trial = {rem_in, num_in[QW-1]};
	assign fit   = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk) begin
		rem_q <= fit ? diff[DW-1:0] : trial[DW-1:0];
		num_q <= {num_in[QW-2:0], 1'b0};
		quo_q <= {quo_in[QW-2:0], fit};
	end

	assign rem_out = rem_q;
	assign num_out = num_q;
	assign quo_out = quo_q;
endmodule

// ===== src/uvs_div_chain.sv =====
// ----------------------------------------------------------------------------
// uvs_div_chain: row of division cells, one quotient bit per cell
// Takes a new numerator every cycle; each cell registers its partial result.
// ----------------------------------------------------------------------------
module uvs_div_chain #(
	parameter int NW = uvs_pkg::DIV_NW,
	parameter int QW = uvs_pkg::DIV_QW,
	parameter int DW = uvs_pkg::DIV_DW
) (
	input  logic          clk,
	input  logic [NW-1:0] numer,
	input  logic [DW-1:0] divisor,
	output logic [QW-1:0] quotient
);
	logic [DW-1:0] rem_w [0:QW];
	logic [QW-1:0] num_w [0:QW];
	logic [QW-1:0] quo_w [0:QW];

	// Quotient fits QW bits, so the upper numerator bits sit below the divisor
	assign rem_w[0] = DW'(numer[NW-1:QW]);
	assign num_w[0] = numer[QW-1:0];
	assign quo_w[0] = '0;

	for (genvar k = 0; k < QW; k++) begin : g_cell
		uvs_div_cell #(
			.QW(QW),
			.DW(DW)
		) u_cell (
			.clk    (clk),
			.divisor(divisor),
			.rem_in (rem_w[k]),
			.num_in (num_w[k]),
			.quo_in (quo_w[k]),
			.rem_out(rem_w[k+1]),
			.num_out(num_w[k+1]),
			.quo_out(quo_w[k+1])
		);
	end

	assign quotient = quo_w[QW];
endmodule

// ===== src/uvs_sine.sv =====
// ----------------------------------------------------------------------------
// uvs_sine: pipelined fixed-point sine of a 16-bit phase
// Quarter-wave polynomial, one multiply per stage, four stages.
// ----------------------------------------------------------------------------
module uvs_sine (
	input  logic               clk,
	input  logic [15:0]        phase,
	output logic signed [15:0] sine
);
	import uvs_pkg::*;

	logic [14:0] u;
	logic [29:0] uu;
	logic [31:0] p2;
	logic [31:0] p3;
	logic [31:0] p4;
	logic [15:0] m;

	logic [14:0] u_s1, u_s2, u_s3;
	logic [14:0] u2_s1, u2_s2;
	logic        neg_s1, neg_s2, neg_s3;
	logic [15:0] k1_s2;
	logic [15:0] k2_s3;
	logic signed [15:0] y_s4;

	// Mirror odd quarters, negate the lower half wave
	assign u  = phase[14] ? 15'(15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
	assign uu = u * u;
	assign p2 = {17'b0, u2_s1} * {16'b0, SIN_C};
	assign p3 = {17'b0, u2_s2} * {16'b0, k1_s2};
	assign p4 = {17'b0, u_s3} * {16'b0, k2_s3};
	assign m  = p4[29:14];

	always_ff @(posedge clk) begin
		u_s1   <= u;
		u2_s1  <= uu[28:14];
		neg_s1 <= phase[15];

		u_s2   <= u_s1;
		u2_s2  <= u2_s1;
		neg_s2 <= neg_s1;
		k1_s2  <= SIN_B - p2[29:14];

		u_s3   <= u_s2;
		neg_s3 <= neg_s2;
		k2_s3  <= SIN_A - p3[29:14];

		y_s4   <= neg_s3 ? -$signed(m) : $signed(m);
	end

	assign sine = y_s4;
endmodule

// ===== src/uv_sphere_cell_tessellator.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_cell_tessellator: vertices of one UV sphere grid cell
// After start is taken, the cell's vertices strobe out one a cycle.
// A middle cell issues six vertices, a cap cell three (the vertex issue sequencer).
// Angle and texture divides run in 17-cell division chains, one bit per cell.
// Reset clears the sequencer and the strobe pipeline; registers return to defaults.
// The receiver cannot stall: each vertex is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module uv_sphere_cell_tessellator #(
	parameter int MAX_DIVISIONS = uvs_pkg::MAX_DIVISIONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// cell command
	input  logic               start,
	output logic               busy,
	input  logic [9:0]         stack_index,
	input  logic [9:0]         slice_index,
	// vertex results
	output logic               vertex_valid,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic [15:0]        tex_s,
	output logic [15:0]        tex_t,
	output logic               last_vertex
);
	import uvs_pkg::*;

	localparam logic [12:0] CNT_MAX = 13'(MAX_DIVISIONS - 1);
	localparam int CTL_LEN = DIV_QW + SINE_LAT + 1;

	// ---------------- configuration registers ----------------
	logic [15:0] radius_q;
	logic [9:0]  slice_count_q;
	logic [9:0]  stack_count_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q      <= 16'd256;
			slice_count_q <= 10'd16;
			stack_count_q <= 10'd16;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_RADIUS: radius_q      <= pwdata[15:0];
				REG_SLICES: slice_count_q <= pwdata[9:0];
				REG_STACKS: stack_count_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_RADIUS: prdata = {16'b0, radius_q};
			REG_SLICES: prdata = {22'b0, slice_count_q};
			REG_STACKS: prdata = {22'b0, stack_count_q};
			default:    prdata = '0;
		endcase
	end

	// Effective counts: zero acts as one, clamp to one below MAX_DIVISIONS
	logic [9:0] slices;
	logic [9:0] stacks;
	logic [9:0] stacks_m1;
	logic [9:0] slices_m1;

	always_comb begin
		if (slice_count_q == 10'd0) slices = 10'd1;
		else if ({3'b0, slice_count_q} > CNT_MAX) slices = CNT_MAX[9:0];
		else slices = slice_count_q;
		if (stack_count_q == 10'd0) stacks = 10'd1;
		else if ({3'b0, stack_count_q} > CNT_MAX) stacks = CNT_MAX[9:0];
		else stacks = stack_count_q;
	end

	assign stacks_m1 = stacks - 10'd1;
	assign slices_m1 = slices - 10'd1;

	// ---------------- vertex issue sequencer ----------------
	logic       active_q;
	logic [2:0] idx_q;
	cell_kind_t kind_q;
	logic [9:0] st_q;
	logic [9:0] sl_q;
	vtx_info_t  info;
	logic       accept;
	logic [9:0] st_sat;
	logic [9:0] sl_sat;
	cell_kind_t kind_in;

	assign info   = vtx_info(kind_q, idx_q);
	// Free up on the last vertex so the next cell follows without a gap
	assign busy   = active_q & ~info.last;
	assign accept = start & ~busy;

	assign st_sat = (stack_index > stacks_m1) ? stacks_m1 : stack_index;
	assign sl_sat = (slice_index > slices_m1) ? slices_m1 : slice_index;

	always_comb begin
		priority if (st_sat == 10'd0) kind_in = KIND_TOP;
		else if (st_sat == stacks_m1) kind_in = KIND_BOT;
		else kind_in = KIND_MID;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= 3'd0;
			kind_q   <= KIND_TOP;
		end else if (accept) begin
			active_q <= 1'b1;
			idx_q    <= 3'd0;
			kind_q   <= kind_in;
		end else if (active_q) begin
			if (info.last) active_q <= 1'b0;
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_q <= st_sat;
			sl_q <= sl_sat;
		end
	end

	// ---------------- division chains ----------------
	logic [9:0]        stv;
	logic [9:0]        slv;
	logic [10:0]       sl2;
	logic [DIV_NW-1:0] n_phi;
	logic [DIV_NW-1:0] n_th;
	logic [DIV_NW-1:0] n_s;
	logic [DIV_QW-1:0] q_phi;
	logic [DIV_QW-1:0] q_th;
	logic [DIV_QW-1:0] q_s;

	assign stv   = st_q + {9'b0, info.da};
	assign slv   = sl_q + {9'b0, info.db};
	assign sl2   = {slv, info.pole};
	// phi: st*65536/(2*stacks) rounded; theta: sl*131072/(2*slices) rounded
	assign n_phi = {1'b0, stv, 16'b0} + DIV_NW'(stacks);
	assign n_th  = {slv, 17'b0} + DIV_NW'(slices);
	// texture s, with the pole taking the half-slice offset
	assign n_s   = {sl2, 16'b0} + DIV_NW'({slices, 1'b0});

	uvs_div_chain #(.NW(DIV_NW), .QW(DIV_QW), .DW(DIV_DW)) u_div_phi (
		.clk(clk), .numer(n_phi), .divisor(DIV_DW'({stacks, 1'b0})), .quotient(q_phi)
	);
	uvs_div_chain #(.NW(DIV_NW), .QW(DIV_QW), .DW(DIV_DW)) u_div_th (
		.clk(clk), .numer(n_th), .divisor(DIV_DW'({slices, 1'b0})), .quotient(q_th)
	);
	uvs_div_chain #(.NW(DIV_NW), .QW(DIV_QW), .DW(DIV_DW)) u_div_s (
		.clk(clk), .numer(n_s), .divisor({slices, 2'b0}), .quotient(q_s)
	);

	// ---------------- strobe and last-flag pipeline ----------------
	logic [CTL_LEN-1:0] vld_pipe_q;
	logic [CTL_LEN-1:0] last_pipe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_pipe_q <= '0;
		end else begin
			vld_pipe_q <= {vld_pipe_q[CTL_LEN-2:0], active_q};
		end
	end

	always_ff @(posedge clk) begin
		last_pipe_q <= {last_pipe_q[CTL_LEN-2:0], info.last};
	end

	// ---------------- sine units ----------------
	logic [15:0] ph_phi;
	logic [15:0] ph_th;
	logic signed [15:0] sin_phi, cos_phi, sin_th, cos_th;

	assign ph_phi = q_phi[15:0];
	assign ph_th  = q_th[15:0];

	uvs_sine u_sin_phi (.clk(clk), .phase(ph_phi), .sine(sin_phi));
	uvs_sine u_cos_phi (.clk(clk), .phase(ph_phi + 16'd16384), .sine(cos_phi));
	uvs_sine u_sin_th  (.clk(clk), .phase(ph_th), .sine(sin_th));
	uvs_sine u_cos_th  (.clk(clk), .phase(ph_th + 16'd16384), .sine(cos_th));

	// Hold texture coordinates alongside the sine pipeline
	logic [15:0] tex_s_pipe_q [0:SINE_LAT];
	logic [15:0] tex_t_pipe_q [0:SINE_LAT];

	always_ff @(posedge clk) begin
		tex_s_pipe_q[0] <= q_s[15:0];
		tex_t_pipe_q[0] <= 16'd32768 - ph_phi;
		for (int i = 1; i <= SINE_LAT; i++) begin
			tex_s_pipe_q[i] <= tex_s_pipe_q[i-1];
			tex_t_pipe_q[i] <= tex_t_pipe_q[i-1];
		end
	end

	// ---------------- normal stage ----------------
	logic signed [32:0] prod_nx;
	logic signed [32:0] prod_nz;
	logic signed [17:0] rnx;
	logic signed [17:0] rnz;
	logic signed [15:0] nx_s5, ny_s5, nz_s5;

	assign prod_nx = sin_phi * cos_th;
	assign prod_nz = sin_phi * sin_th;
	assign rnx     = rmul14(prod_nx);
	assign rnz     = rmul14(prod_nz);

	always_ff @(posedge clk) begin
		nx_s5 <= rnx[15:0];
		ny_s5 <= cos_phi;
		nz_s5 <= rnz[15:0];
	end

	// ---------------- position and output stage ----------------
	logic signed [16:0] r_s;
	logic signed [32:0] prod_px, prod_py, prod_pz;
	logic signed [17:0] rpx, rpy, rpz;
	logic               vld_q;

	assign r_s     = $signed({1'b0, radius_q});
	assign prod_px = r_s * nx_s5;
	assign prod_py = r_s * ny_s5;
	assign prod_pz = r_s * nz_s5;
	assign rpx     = rmul14(prod_px);
	assign rpy     = rmul14(prod_py);
	assign rpz     = rmul14(prod_pz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_pipe_q[CTL_LEN-1];
		end
	end

	always_ff @(posedge clk) begin
		pos_x       <= rpx[16:0];
		pos_y       <= rpy[16:0];
		pos_z       <= rpz[16:0];
		norm_x      <= nx_s5;
		norm_y      <= ny_s5;
		norm_z      <= nz_s5;
		tex_s       <= tex_s_pipe_q[SINE_LAT];
		tex_t       <= tex_t_pipe_q[SINE_LAT];
		last_vertex <= last_pipe_q[CTL_LEN-1];
	end

	assign vertex_valid = vld_q;
endmodule
